// ----- hdl/mcmp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcmp_pkg
// Shared types and constants for the MIDI channel message parser.
// ----------------------------------------------------------------------------
package mcmp_pkg;

    localparam int unsigned BYTE_W = 8;

    // Byte classes
    localparam logic [BYTE_W-1:0] REALTIME_MIN = 8'hF8;
    localparam logic [BYTE_W-1:0] SYSTEM_MIN   = 8'hF0;

    // Message kinds (upper nibble of the status byte)
    localparam logic [3:0] KIND_PROGRAM  = 4'hC;
    localparam logic [3:0] KIND_PRESSURE = 4'hD;

    // Parse phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } t_phase;

    // One complete channel-voice message
    typedef struct packed {
        logic [BYTE_W-1:0] msg_status;
        logic [BYTE_W-1:0] first_data;
        logic [BYTE_W-1:0] second_data;
    } t_msg;

    // Parser result for one byte
    typedef struct packed {
        logic emit;
        t_msg msg;
    } t_parse_res;

    // Kinds that carry a single data byte
    function automatic logic one_data_kind(input logic [BYTE_W-1:0] status);
        return (status[7:4] == KIND_PROGRAM) || (status[7:4] == KIND_PRESSURE);
    endfunction

endpackage
`default_nettype wire

// ----- hdl/mcmp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcmp_if
// Valid/ready channels: raw MIDI bytes in, assembled messages out.
// ----------------------------------------------------------------------------
interface mcmp_byte_if
    import mcmp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] midi_byte;

    modport source (output valid, output midi_byte, input ready);
    modport sink   (input valid, input midi_byte, output ready);
endinterface

interface mcmp_msg_if
    import mcmp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] msg_status;
    logic [BYTE_W-1:0] first_data;
    logic [BYTE_W-1:0] second_data;

    modport source (output valid, output msg_status, output first_data,
                    output second_data, input ready);
    modport sink   (input valid, input msg_status, input first_data,
                    input second_data, output ready);
endinterface
`default_nettype wire

// ----- hdl/midi_channel_message_parser_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// midi_channel_message_parser_unit
// MIDI channel-voice message parser with running status.
// ----------------------------------------------------------------------------
// Takes one MIDI byte per transaction and returns a message (status, first
// data, second data) when a channel-voice message completes; program change
// and channel pressure return second data of zero. The unit accepts one byte
// every cycle unless the output side stalls: a byte is registered, parsed by
// the phase machine, and the message lands in an output register. The only
// stall comes from the output side: when the output register holds a message
// that is not taken, the input register holds and input ready drops.
// ----------------------------------------------------------------------------
module midi_channel_message_parser_unit
    import mcmp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    mcmp_byte_if.sink     i_byte,
    mcmp_msg_if.source    o_msg
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_msg              r_out_msg;
    logic              w_out_free;
    logic              w_step;
    t_parse_res        w_res;

    // Handshake: parser steps when the output register can take a result
    assign w_out_free   = !r_out_valid || o_msg.ready;
    assign w_step       = r_in_valid && w_out_free;
    assign i_byte.ready = !r_in_valid || w_out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.midi_byte;
        end
    end

    // Phase machine
    mcmp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_msg.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res.emit) begin
            r_out_msg <= w_res.msg;
        end
    end

    assign o_msg.valid       = r_out_valid;
    assign o_msg.msg_status  = r_out_msg.msg_status;
    assign o_msg.first_data  = r_out_msg.first_data;
    assign o_msg.second_data = r_out_msg.second_data;

    // Checks
    a_status_channel_voice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_msg.msg_status[7] && (r_out_msg.msg_status[7:4] != 4'hF)))
        else $error("message status outside channel-voice range");

    a_one_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && one_data_kind(r_out_msg.msg_status)) |->
            (r_out_msg.second_data == '0))
        else $error("one-data message with nonzero second data");

    a_in_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register lost a byte during output stall");

endmodule
`default_nettype wire

// ----- hdl/mcmp_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mcmp_parser
// Running-status phase machine: consumes one byte per step and reports a
// message when the last data byte arrives.
// ----------------------------------------------------------------------------
module mcmp_parser
    import mcmp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [BYTE_W-1:0] i_byte,
    output t_parse_res             o_res
);

    t_phase            r_phase, n_phase;
    logic [BYTE_W-1:0] r_running_status, n_running_status;
    logic [BYTE_W-1:0] r_held, n_held;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_running_status <= '0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_running_status <= n_running_status;
        end
    end

    // Held first data byte: only read after being written
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_held <= n_held;
        end
    end

    // Next state and result
    always_comb begin
        logic take_first;
        take_first       = 1'b0;
        n_phase          = r_phase;
        n_running_status = r_running_status;
        n_held           = r_held;
        o_res.emit             = 1'b0;
        o_res.msg.msg_status   = r_running_status;
        o_res.msg.first_data   = i_byte;
        o_res.msg.second_data  = '0;

        unique case (r_phase)
            PH_FIRST: begin
                take_first = 1'b1;
            end
            PH_SECOND: begin
                o_res.emit            = 1'b1;
                o_res.msg.first_data  = r_held;
                o_res.msg.second_data = i_byte;
                n_phase               = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_byte >= REALTIME_MIN) begin
                    // realtime: ignored
                end else if (i_byte >= SYSTEM_MIN) begin
                    n_running_status = '0;
                end else if (i_byte[7]) begin
                    n_running_status = i_byte;
                    n_phase          = PH_FIRST;
                end else if (r_running_status[7]) begin
                    take_first = 1'b1;
                end
            end
        endcase

        // First data byte of the remembered status
        if (take_first) begin
            if (one_data_kind(r_running_status)) begin
                o_res.emit = 1'b1;
                n_phase    = PH_IDLE;
            end else begin
                n_held  = i_byte;
                n_phase = PH_SECOND;
            end
        end
    end

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MIDI channel message parser unit. Raw bytes go
// in over the byte channel with random gaps while the message side stalls at
// random. A scoreboard class tracks running status and parse phase on its own
// and compares every message that comes out against the oldest one it holds.
// ----------------------------------------------------------------------------
module testbench;
    import mcmp_pkg::*;

    localparam int unsigned RANDOM_BYTES   = 1150;
    localparam int unsigned DIRECTED_BYTES = 26;
    localparam int unsigned STALL_LIMIT    = 2000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned MAX_REPORTS    = 10;

    // Predicts messages from accepted bytes and checks the unit's output
    class midi_msg_scoreboard;
        logic [7:0] run_status;
        t_phase     phase;
        logic [7:0] held_data;
        t_msg       pending_msgs[$];
        int         mismatches;

        function new();
            run_status = 8'h00;
            phase      = PH_IDLE;
            held_data  = 8'h00;
            mismatches = 0;
        endfunction

        // First data byte under the remembered status
        function void take_first(logic [7:0] b);
            t_msg m;
            if (run_status[7:4] == KIND_PROGRAM || run_status[7:4] == KIND_PRESSURE) begin
                m.msg_status  = run_status;
                m.first_data  = b;
                m.second_data = 8'h00;
                pending_msgs.push_back(m);
                phase = PH_IDLE;
            end else begin
                held_data = b;
                phase     = PH_SECOND;
            end
        endfunction

        // One accepted byte
        function void note_byte(logic [7:0] b);
            t_msg m;
            case (phase)
                PH_FIRST: begin
                    take_first(b);
                end
                PH_SECOND: begin
                    m.msg_status  = run_status;
                    m.first_data  = held_data;
                    m.second_data = b;
                    pending_msgs.push_back(m);
                    phase = PH_IDLE;
                end
                default: begin
                    phase = PH_IDLE;
                    if (b >= REALTIME_MIN) begin
                        // realtime: nothing changes
                    end else if (b >= SYSTEM_MIN) begin
                        run_status = 8'h00;
                    end else if (b[7]) begin
                        run_status = b;
                        phase      = PH_FIRST;
                    end else if (run_status[7]) begin
                        take_first(b);
                    end
                    // else: data byte with no status, dropped
                end
            endcase
        endfunction

        // One accepted message
        function void check_msg(t_msg got);
            t_msg want;
            if (pending_msgs.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected message: status %h first %h second %h",
                             got.msg_status, got.first_data, got.second_data);
                return;
            end
            want = pending_msgs.pop_front();
            if (got.msg_status !== want.msg_status || got.first_data !== want.first_data ||
                got.second_data !== want.second_data) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("message mismatch: expected %h %h %h, got %h %h %h",
                             want.msg_status, want.first_data, want.second_data,
                             got.msg_status, got.first_data, got.second_data);
            end
        endfunction

        function int outstanding();
            return pending_msgs.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   bytes_sent;
    int   quiet_cycles;

    midi_msg_scoreboard sb;

    mcmp_byte_if byte_ch ();
    mcmp_msg_if  msg_ch ();

    midi_channel_message_parser_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_ch.sink),
        .o_msg   (msg_ch.source)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Monitor: sample both channels at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (byte_ch.valid && byte_ch.ready)
                sb.note_byte(byte_ch.midi_byte);
            if (msg_ch.valid && msg_ch.ready)
                sb.check_msg({msg_ch.msg_status, msg_ch.first_data, msg_ch.second_data});
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge clk) begin
        if (rst_n) begin
            if ((byte_ch.valid && byte_ch.ready) || (msg_ch.valid && msg_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Message side: random stalls unless in the calm stretch
    initial begin
        msg_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            msg_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 26);
        end
    end

    // Send one byte, with random idle cycles ahead of it
    task automatic push_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 26) begin
            @(negedge clk);
            byte_ch.valid <= 1'b0;
        end
        @(negedge clk);
        byte_ch.valid     <= 1'b1;
        byte_ch.midi_byte <= b;
        do @(posedge clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // Extremes and each special case
    task automatic run_directed();
        push_byte(8'hF8);   // realtime while idle
        push_byte(8'hFF);
        push_byte(8'hF0);   // system while idle
        push_byte(8'h00);   // data with no status
        push_byte(8'h7F);
        push_byte(8'h90);   // note on, two data bytes
        push_byte(8'h3C);
        push_byte(8'h7F);
        push_byte(8'h00);   // running status
        push_byte(8'h00);
        push_byte(8'hC5);   // program change, one data byte
        push_byte(8'h7F);
        push_byte(8'h12);   // running program change
        push_byte(8'hD0);   // channel pressure
        push_byte(8'h00);
        push_byte(8'hEF);   // status bytes taken as data in data phases
        push_byte(8'hFF);
        push_byte(8'h80);
        push_byte(8'h80);   // realtime and system taken as data
        push_byte(8'hF8);
        push_byte(8'hF7);
        push_byte(8'hB3);
        push_byte(8'h05);
        push_byte(8'h06);
        push_byte(8'hF5);   // clears running status
        push_byte(8'h40);   // now dropped
    endtask

    // Mostly well-formed messages, some stray and broken traffic
    task automatic run_random();
        int         pick;
        int         msgs;
        int         nbytes;
        logic [7:0] status;
        while (bytes_sent < RANDOM_BYTES + DIRECTED_BYTES) begin
            calm = (bytes_sent >= 400 && bytes_sent < 700);
            pick = $urandom_range(99);
            if (pick < 70) begin
                status = 8'($urandom_range(8'h80, 8'hEF));
                push_byte(status);
                msgs = $urandom_range(1, 4);
                repeat (msgs) begin
                    push_byte(8'($urandom_range(0, 127)));
                    if (!(status[7:4] == KIND_PROGRAM || status[7:4] == KIND_PRESSURE)) begin
                        // occasionally cut the message short with a new status
                        if ($urandom_range(99) < 5)
                            push_byte(8'($urandom_range(8'h80, 8'hEF)));
                        else
                            push_byte(8'($urandom_range(0, 127)));
                    end
                end
            end else if (pick < 82) begin
                push_byte(8'($urandom_range(8'hF0, 8'hFF)));
            end else begin
                nbytes = $urandom_range(1, 3);
                repeat (nbytes) push_byte(8'($urandom_range(0, 255)));
            end
        end
        calm = 1'b0;
    endtask

    // Main sequence
    initial begin
        rst_n             = 1'b0;
        calm              = 1'b0;
        bytes_sent        = 0;
        quiet_cycles      = 0;
        byte_ch.valid     = 1'b0;
        byte_ch.midi_byte = 8'h00;
        sb = new();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random();
        @(negedge clk);
        byte_ch.valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
